FILE: hw/rtl/sparse_matrix_hash_store_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse matrix hash store
// Clocked implication checks, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_HASH_STORE_TOP_MACROS_SVH
`define SPARSE_MATRIX_HASH_STORE_TOP_MACROS_SVH

// same-cycle implication
`define SMHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/smhs_pkg.sv
// ----------------------------------------------------------------------------
// smhs_pkg
// Shared widths, codes and types of the sparse matrix hash store.
// ----------------------------------------------------------------------------
package smhs_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 16;
  localparam int CC_W      = 17;
  localparam int BC_W      = 9;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int REM_W     = BC_W;
  localparam int DIV_BITS  = 4;
  localparam int DIV_CYC   = KEY_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUCKET_COUNT = 2'd1;

  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_GET = 1'b1;

  localparam logic [CC_W-1:0] COLUMN_COUNT_RST = 17'd1;
  localparam logic [BC_W-1:0] BUCKET_COUNT_RST = 9'd256;

  typedef struct packed {
    logic             done;
    logic [KEY_W-1:0] key;
    logic [REM_W-1:0] rem;
  } key_stat_t;

endpackage

FILE: hw/rtl/smhs_ram.sv
// ----------------------------------------------------------------------------
// smhs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/smhs_key_unit.sv
// ----------------------------------------------------------------------------
// smhs_key_unit
// Forms the linear key and reduces it modulo the bucket count, clamped to
// 1..MAX_BUCKETS, four quotient bits per cycle via chained compare-subtract.
// ----------------------------------------------------------------------------
module smhs_key_unit #(
  parameter int MAX_BUCKETS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [smhs_pkg::ROW_W-1:0] row_index,
  input  logic [smhs_pkg::COL_W-1:0] col_index,
  input  logic [smhs_pkg::CC_W-1:0]  column_count,
  input  logic [smhs_pkg::BC_W-1:0]  bucket_count,
  output smhs_pkg::key_stat_t        stat
);
  import smhs_pkg::*;

  typedef enum logic [1:0] {K_IDLE, K_MUL, K_ADD, K_DIV} kstate_t;

  kstate_t                state_r;
  logic [ROW_W-1:0]       row_r;
  logic [COL_W-1:0]       col_r;
  logic [CC_W-1:0]        cc_r;
  logic [REM_W-1:0]       n_r;
  logic [KEY_W-1:0]       prod_r;
  logic [KEY_W-1:0]       key_r;
  logic [KEY_W-1:0]       sh_r;
  logic [REM_W-1:0]       rem_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   done_r;
  logic [REM_W-1:0]       n_eff;
  logic [ROW_W+CC_W-1:0]  prod_full;
  logic [KEY_W-1:0]       sh_nxt;
  logic [REM_W-1:0]       rem_nxt;

  always_comb begin
    priority if (bucket_count == '0) begin
      n_eff = REM_W'(1);
    end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
      n_eff = REM_W'(MAX_BUCKETS);
    end else begin
      n_eff = bucket_count;
    end
  end

  assign prod_full = row_r * cc_r;

  always_comb begin : div_step
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    logic [KEY_W-1:0] s;
    r = rem_r;
    s = sh_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, s[KEY_W-1]};
      s = {s[KEY_W-2:0], 1'b0};
      if (t >= {1'b0, n_r}) begin
        t = t - {1'b0, n_r};
      end
      r = t[REM_W-1:0];
    end
    sh_nxt  = s;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= K_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        K_IDLE: begin
          if (start) begin
            row_r   <= row_index;
            col_r   <= col_index;
            cc_r    <= column_count;
            n_r     <= n_eff;
            state_r <= K_MUL;
          end
        end
        K_MUL: begin
          prod_r  <= prod_full[KEY_W-1:0];
          state_r <= K_ADD;
        end
        K_ADD: begin
          key_r   <= prod_r + KEY_W'(col_r);
          sh_r    <= prod_r + KEY_W'(col_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= K_DIV;
        end
        K_DIV: begin
          sh_r  <= sh_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
            done_r  <= 1'b1;
            state_r <= K_IDLE;
          end
        end
        default: state_r <= K_IDLE;
      endcase
    end
  end

  assign stat.done = done_r;
  assign stat.key  = key_r;
  assign stat.rem  = rem_r;

endmodule

FILE: hw/rtl/sparse_matrix_hash_store_top.sv
// ----------------------------------------------------------------------------
// sparse_matrix_hash_store_top
// Sparse matrix kept as a chained hash table over a fixed entry pool.
// ----------------------------------------------------------------------------
// Sequence: the key unit forms the key by multiply and add, then reduces it by a
// modulo at 4 bits/cycle; the bucket head is read from a registered RAM, and a
// get then follows the chain links through the pool to a key match or its end.
// Handshake: busy drops with the strobe, so the next start is taken in the
// strobe cycle; a new request is taken only once the last one has returned.
// Reset: busy for MAX_BUCKETS cycles while the bucket heads are cleared.
module sparse_matrix_hash_store_top #(
  parameter int MAX_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [smhs_pkg::ROW_W-1:0]     in_row_index,
  input  logic [smhs_pkg::COL_W-1:0]     in_col_index,
  input  logic [smhs_pkg::VAL_W-1:0]     in_write_value,
  output logic                           out_valid,
  output logic [smhs_pkg::VAL_W-1:0]     out_read_value,
  output logic                           out_found,
  output logic                           out_pool_full,
  input  logic                           cfg_wr_en,
  input  logic [smhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smhs_pkg::CFG_W-1:0]     cfg_wdata
);
  import smhs_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int EW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int PW = KEY_W + VAL_W + LW;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD, S_CHAIN} state_t;

  state_t           state_r;
  logic [BW-1:0]    clr_idx_r;
  logic             req_get_r;
  logic [VAL_W-1:0] wval_r;
  logic [BW-1:0]    bucket_r;
  logic [LW-1:0]    used_r;
  logic [CC_W-1:0]  column_count_r;
  logic [BC_W-1:0]  bucket_count_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic             out_found_r;
  logic             out_pool_full_r;

  key_stat_t        kstat;
  logic             key_start;

  logic             bkt_we;
  logic [BW-1:0]    bkt_waddr;
  logic [LW-1:0]    bkt_wdata;
  logic [LW-1:0]    bkt_rdata;

  logic             pool_we;
  logic [EW-1:0]    pool_raddr;
  logic [PW-1:0]    pool_wdata;
  logic [PW-1:0]    pool_rdata;
  logic [KEY_W-1:0] ent_key;
  logic [VAL_W-1:0] ent_val;
  logic [LW-1:0]    ent_link;
  logic             pool_has_room;

  assign key_start     = (state_r == S_IDLE) && start;
  assign busy          = (state_r != S_IDLE);
  assign ent_key       = pool_rdata[PW-1 -: KEY_W];
  assign ent_val       = pool_rdata[LW +: VAL_W];
  assign ent_link      = pool_rdata[LW-1:0];
  assign pool_has_room = (used_r != NULL_LINK);
  assign pool_wdata    = {kstat.key, wval_r, bkt_rdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COLUMN_COUNT_RST;
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_COLUMN_COUNT: column_count_r <= cfg_wdata[CC_W-1:0];
        CFG_IDX_BUCKET_COUNT: bucket_count_r <= cfg_wdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  smhs_key_unit #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_key (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (key_start),
    .row_index   (in_row_index),
    .col_index   (in_col_index),
    .column_count(column_count_r),
    .bucket_count(bucket_count_r),
    .stat        (kstat)
  );

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = bucket_r;
    bkt_wdata = LW'(used_r);
    pool_we   = 1'b0;
    pool_raddr = EW'(bkt_rdata);
    unique case (state_r)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_idx_r;
        bkt_wdata = NULL_LINK;
      end
      S_HEAD: begin
        if ((req_get_r == REQ_SET) && pool_has_room) begin
          bkt_we  = 1'b1;
          pool_we = 1'b1;
        end
      end
      S_CHAIN: pool_raddr = EW'(ent_link);
      default: ;
    endcase
  end

  smhs_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_BUCKETS),
    .AW   (BW)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (bkt_we),
    .waddr(bkt_waddr),
    .wdata(bkt_wdata),
    .raddr(bucket_r),
    .rdata(bkt_rdata)
  );

  smhs_ram #(
    .WIDTH(PW),
    .DEPTH(POOL_ENTRIES),
    .AW   (EW)
  ) u_pool_ram (
    .clk  (clk),
    .we   (pool_we),
    .waddr(EW'(used_r)),
    .wdata(pool_wdata),
    .raddr(pool_raddr),
    .rdata(pool_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == BW'(MAX_BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_get_r <= in_req_type;
            wval_r    <= in_write_value;
            state_r   <= S_HASH;
          end
        end
        S_HASH: begin
          if (kstat.done) begin
            bucket_r <= BW'(kstat.rem);
            state_r  <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: state_r <= S_HEAD;
        S_HEAD: begin
          if (req_get_r == REQ_SET) begin
            if (pool_has_room) begin
              used_r <= used_r + 1'b1;
            end
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_found_r      <= 1'b0;
            out_pool_full_r  <= !pool_has_room;
            state_r          <= S_IDLE;
          end else if (bkt_rdata < used_r) begin
            state_r <= S_CHAIN;
          end else begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_found_r      <= 1'b0;
            out_pool_full_r  <= 1'b0;
            state_r          <= S_IDLE;
          end
        end
        S_CHAIN: begin
          if (ent_key == kstat.key) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= ent_val;
            out_found_r      <= 1'b1;
            out_pool_full_r  <= 1'b0;
            state_r          <= S_IDLE;
          end else if (!(ent_link < used_r)) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_found_r      <= 1'b0;
            out_pool_full_r  <= 1'b0;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_found      = out_found_r;
  assign out_pool_full  = out_pool_full_r;

endmodule

FILE: hw/rtl/smhs_checker.sv
// ----------------------------------------------------------------------------
// smhs_checker
// Port-level checks of the sparse matrix hash store, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_matrix_hash_store_top_macros.svh"

module smhs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_read_value,
  input logic        out_found,
  input logic        out_pool_full
);

  `SMHS_ASSERT_IMP(a_idle_on_result, out_valid, !busy, "result beat while busy")
  `SMHS_ASSERT_NXT(a_single_beat, out_valid, !out_valid, "result beat repeated")
  `SMHS_ASSERT_IMP(a_busy_from_start, $rose(busy), $past(start), "busy without start")
  `SMHS_ASSERT_IMP(a_full_clean, out_valid && out_pool_full, out_read_value == 32'd0 && !out_found, "dropped set returned data")

endmodule

bind sparse_matrix_hash_store_top smhs_checker u_smhs_checker (.*);
